// File: hw/rtl/qbe_pkg.sv
// Shared constants and types for the quoted byte escaper.
package qbe_pkg;

  localparam int QueueDepth = 4;
  localparam int MaxBytes   = 7;
  localparam int CountW     = 3;

  localparam logic [7:0] QuoteCh     = 8'h22;
  localparam logic [7:0] BackslashCh = 8'h5C;
  localparam logic [7:0] NewlineCh   = 8'h0A;
  localparam logic [7:0] CrCh        = 8'h0D;
  localparam logic [7:0] TabCh       = 8'h09;
  localparam logic [7:0] LowPrint    = 8'd32;
  localparam logic [7:0] DelCh       = 8'd127;
  localparam logic [7:0] ZeroCh      = 8'h00;

  // one queued request: the expanded output text and how many bytes it holds
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CountW-1:0]        count;
  } entry_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    if (v < 4'd10) begin
      return 8'h30 + {4'd0, v};
    end else begin
      return 8'h41 + {4'd0, v} - 8'd10;
    end
  endfunction

endpackage

// File: hw/rtl/qbe_if.sv
// Channel interfaces for raw input bytes and escaped output bytes.
interface qbe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       first_of_message;
  logic       last_of_message;
  logic       no_data;

  modport source (output valid, in_byte, first_of_message, last_of_message, no_data,
                  input ready);
  modport sink (input valid, in_byte, first_of_message, last_of_message, no_data,
                output ready);
endinterface

interface qbe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink (input valid, out_byte, last_of_run, output ready);
endinterface

// File: hw/rtl/qbe_front.sv
// Front end: accepts input requests and expands each into a byte list.
module qbe_front (
  qbe_in_if.sink          byte_in,
  input  logic            q_ready,
  output logic            push,
  output qbe_pkg::entry_t entry
);

  logic [7:0]                 c;
  logic [3:0][7:0]            esc;
  logic [2:0]                 esc_len;
  logic [qbe_pkg::CountW-1:0] pos;

  assign c = byte_in.in_byte;

  always_comb begin
    esc     = '0;
    esc_len = 3'd0;
    if (!byte_in.no_data) begin
      unique case (c)
        qbe_pkg::NewlineCh: begin
          esc[0] = qbe_pkg::BackslashCh; esc[1] = 8'h6E; esc_len = 3'd2;
        end
        qbe_pkg::CrCh: begin
          esc[0] = qbe_pkg::BackslashCh; esc[1] = 8'h72; esc_len = 3'd2;
        end
        qbe_pkg::TabCh: begin
          esc[0] = qbe_pkg::BackslashCh; esc[1] = 8'h74; esc_len = 3'd2;
        end
        qbe_pkg::BackslashCh, qbe_pkg::QuoteCh: begin
          esc[0] = qbe_pkg::BackslashCh; esc[1] = c; esc_len = 3'd2;
        end
        default: begin
          if (c < qbe_pkg::LowPrint || c >= qbe_pkg::DelCh) begin
            esc[0]  = qbe_pkg::BackslashCh;
            esc[1]  = 8'h78;
            esc[2]  = qbe_pkg::hex_digit(c[7:4]);
            esc[3]  = qbe_pkg::hex_digit(c[3:0]);
            esc_len = 3'd4;
          end else begin
            esc[0]  = c;
            esc_len = 3'd1;
          end
        end
      endcase
    end
  end

  // pack opening quote, escape bytes and closing quote/zero
  always_comb begin
    entry = '0;
    pos   = '0;
    if (byte_in.first_of_message) begin
      entry.bytes[0] = qbe_pkg::QuoteCh;
      pos            = 3'd1;
    end
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < esc_len) begin
        entry.bytes[pos] = esc[i];
        pos              = pos + 3'd1;
      end
    end
    if (byte_in.last_of_message) begin
      entry.bytes[pos] = qbe_pkg::QuoteCh;
      pos              = pos + 3'd1;
      entry.bytes[pos] = qbe_pkg::ZeroCh;
      pos              = pos + 3'd1;
    end
    entry.count = pos;
  end

  assign byte_in.ready = q_ready;
  // requests that expand to nothing are dropped here
  assign push = byte_in.valid && q_ready && (entry.count != '0);

endmodule

// File: hw/rtl/qbe_queue.sv
// Small register FIFO between front and back end.
module qbe_queue #(
  parameter int DEPTH = qbe_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  qbe_pkg::entry_t wr_entry,
  output logic            not_full,
  input  logic            pop,
  output logic            not_empty,
  output qbe_pkg::entry_t head
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  qbe_pkg::entry_t mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign not_full  = (count != CntW'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/qbe_back.sv
// Back end: walks the head entry and sends one byte per cycle while the output is ready.
module qbe_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            not_empty,
  input  qbe_pkg::entry_t head,
  output logic            pop,
  qbe_out_if.source       byte_out
);

  logic [qbe_pkg::CountW-1:0] idx;
  logic                       load;
  logic                       at_end;
  logic                       out_valid;
  logic [7:0]                 out_byte;
  logic                       out_last;

  assign load   = not_empty && (!out_valid || byte_out.ready);
  assign at_end = (idx == head.count - 1'b1);
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_end ? '0 : idx + 1'b1;
      end else if (byte_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= head.bytes[idx];
      out_last <= at_end;
    end
  end

  assign byte_out.valid       = out_valid;
  assign byte_out.out_byte    = out_byte;
  assign byte_out.last_of_run = out_last;

endmodule

// File: hw/rtl/quoted_byte_escaper_top.sv
// Quoted byte escaper: raw bytes in, quoted C-style escaped text out.
// The first output byte passes through the entry queue and then the output register.
// Output: one byte per cycle while byte_out.ready is high; a request expands to 0 to 7 bytes,
// so a hex escape with both quotes (quote, four escape bytes, quote, zero) gives 7.
// Input stays ready while the entry queue has room, independent of output stalls.
// Reset (rst, synchronous) empties the queue and clears the output valid flag.
module quoted_byte_escaper_top #(
  parameter int QUEUE_DEPTH = qbe_pkg::QueueDepth
) (
  input logic       clk,
  input logic       rst,
  qbe_in_if.sink    byte_in,
  qbe_out_if.source byte_out
);

  qbe_pkg::entry_t wr_entry;
  qbe_pkg::entry_t head;
  logic            push;
  logic            not_full;
  logic            not_empty;
  logic            pop;

  qbe_front u_front (
    .byte_in (byte_in),
    .q_ready (not_full),
    .push    (push),
    .entry   (wr_entry)
  );

  qbe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_entry  (wr_entry),
    .not_full  (not_full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  qbe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop),
    .byte_out  (byte_out)
  );

endmodule
